// File: sv/pcle_pkg.sv
// shared constants, codes and controller/datapath interface types for the list engine
`default_nettype none

package pcle_pkg;

    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int POS_W    = 7;
    localparam int CNT_OUT_W = 7;
    localparam int ST_W     = 2;
    // store index and element count widths
    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = $clog2(CAPACITY + 1);
    // width for comparing a position against the count
    localparam int CMP_W    = ((POS_W > CW) ? POS_W : CW) + 1;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_POS   = 3'd1,
        OP_DEL_POS   = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_READ_ALL  = 3'd4
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef struct packed {
        logic latch;
        logic decode;
        logic start_ins;
        logic start_del;
        logic start_rd;
        logic shift_up;
        logic shift_dn;
        logic rd_issue;
        logic load_elem;
        logic load_single;
    } cmd_t;

    typedef struct packed {
        logic is_ins;
        logic is_del;
        logic is_rd;
        logic fail;
        logic up_done;
        logic dn_done;
        logic rd_last;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// File: sv/pcle_ctrl.sv
// sequencing state machine for the list engine
`default_nettype none

module pcle_ctrl
    import pcle_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    input  stat_t      st,
    output cmd_t       cmd
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DECODE   = 7'b0000010,
        S_SHIFT_UP = 7'b0000100,
        S_SHIFT_DN = 7'b0001000,
        S_RD_ISSUE = 7'b0010000,
        S_RD_EMIT  = 7'b0100000,
        S_EMIT     = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        s_ready    = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.decode = 1'b1;
                if (st.fail) begin
                    state_next = S_EMIT;
                end else if (st.is_ins) begin
                    cmd.start_ins = 1'b1;
                    state_next    = S_SHIFT_UP;
                end else if (st.is_del) begin
                    cmd.start_del = 1'b1;
                    state_next    = S_SHIFT_DN;
                end else if (st.is_rd) begin
                    cmd.start_rd = 1'b1;
                    state_next   = S_RD_ISSUE;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_SHIFT_UP: begin
                cmd.shift_up = 1'b1;
                if (st.up_done) begin
                    state_next = S_EMIT;
                end
            end
            S_SHIFT_DN: begin
                cmd.shift_dn = 1'b1;
                if (st.dn_done) begin
                    state_next = S_EMIT;
                end
            end
            S_RD_ISSUE: begin
                cmd.rd_issue = 1'b1;
                state_next   = S_RD_EMIT;
            end
            S_RD_EMIT: begin
                if (st.out_free) begin
                    cmd.load_elem = 1'b1;
                    state_next    = st.rd_last ? S_IDLE : S_RD_ISSUE;
                end
            end
            S_EMIT: begin
                if (st.out_free) begin
                    cmd.load_single = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/pcle_dp.sv
// element store, count, shift pointers, checks and result register
`default_nettype none

module pcle_dp
    import pcle_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic [OP_W-1:0]          s_opcode,
    input  wire logic signed [DATA_W-1:0] s_value,
    input  wire logic [POS_W-1:0]         s_position,
    input  cmd_t                          cmd,
    output stat_t                         st,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [ST_W-1:0]               m_status,
    output logic signed [DATA_W-1:0]      m_data_out,
    output logic [CNT_OUT_W-1:0]          m_count,
    output logic                          m_last
);

    logic signed [DATA_W-1:0] mem [CAPACITY];

    op_t                      op_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic [POS_W-1:0]         pos_reg;

    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            ptr_reg, ptr_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic                     rd_vld_reg, rd_vld_next;
    logic [AW-1:0]            rd_addr_reg, rd_addr_next;
    status_t                  res_code_reg, res_code_next;
    logic signed [DATA_W-1:0] res_data_reg, res_data_next;
    logic signed [DATA_W-1:0] rdata_reg;

    logic                     m_valid_reg, m_valid_next;
    logic [ST_W-1:0]          m_status_reg;
    logic signed [DATA_W-1:0] m_data_reg;
    logic [CNT_OUT_W-1:0]     m_count_reg;
    logic                     m_last_reg;

    logic                     we, re;
    logic [AW-1:0]            waddr, raddr;
    logic signed [DATA_W-1:0] wdata;

    // position checks against the current count
    logic [CMP_W-1:0]         pos_x, cnt_x;
    logic                     full, empty;
    status_t                  code_c;
    logic [CW-1:0]            idx_c;
    logic                     is_ins, is_del, is_rd;

    always_comb begin
        pos_x  = CMP_W'(pos_reg);
        cnt_x  = CMP_W'(count_reg);
        full   = (count_reg == CW'(CAPACITY));
        empty  = (count_reg == '0);
        idx_c  = '0;
        is_ins = 1'b0;
        is_del = 1'b0;
        is_rd  = 1'b0;
        code_c = ST_OK;
        case (op_reg)
            OP_INS_FRONT: begin
                is_ins = 1'b1;
                code_c = full ? ST_FULL : ST_OK;
            end
            OP_INS_POS: begin
                is_ins = 1'b1;
                idx_c  = CW'(pos_reg - POS_W'(1));
                if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) begin
                    code_c = ST_BADPOS;
                end else if (full) begin
                    code_c = ST_FULL;
                end
            end
            OP_DEL_POS: begin
                is_del = 1'b1;
                idx_c  = CW'(pos_reg - POS_W'(1));
                if (pos_x == '0 || pos_x > cnt_x) begin
                    code_c = ST_BADPOS;
                end
            end
            OP_DEL_FRONT: begin
                is_del = 1'b1;
                code_c = empty ? ST_EMPTY : ST_OK;
            end
            OP_READ_ALL: begin
                is_rd  = 1'b1;
                code_c = empty ? ST_EMPTY : ST_OK;
            end
            default: begin
                code_c = ST_BADPOS;
            end
        endcase
    end

    always_comb begin
        st.is_ins   = is_ins;
        st.is_del   = is_del;
        st.is_rd    = is_rd;
        st.fail     = (code_c != ST_OK);
        st.up_done  = (ptr_reg == idx_reg) && !rd_vld_reg;
        st.dn_done  = (ptr_reg == count_reg) && !rd_vld_reg;
        st.rd_last  = ((ptr_reg + CW'(1)) == count_reg);
        st.out_free = !m_valid_reg || m_ready;
    end

    always_comb begin
        we            = 1'b0;
        re            = 1'b0;
        waddr         = '0;
        raddr         = '0;
        wdata         = rdata_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        idx_next      = idx_reg;
        rd_vld_next   = rd_vld_reg;
        rd_addr_next  = rd_addr_reg;
        res_code_next = res_code_reg;
        res_data_next = res_data_reg;

        if (cmd.decode) begin
            idx_next      = idx_c;
            res_code_next = code_c;
            res_data_next = '0;
            rd_vld_next   = 1'b0;
            if (cmd.start_ins) begin
                ptr_next = count_reg;
            end else if (cmd.start_del) begin
                ptr_next = idx_c;
            end else if (cmd.start_rd) begin
                ptr_next = '0;
            end
        end

        // shift up: read slot ptr-1, write it one slot higher next cycle
        if (cmd.shift_up) begin
            if (rd_vld_reg) begin
                we    = 1'b1;
                waddr = rd_addr_reg + AW'(1);
            end
            if (ptr_reg > idx_reg) begin
                re           = 1'b1;
                raddr        = AW'(ptr_reg - CW'(1));
                rd_addr_next = AW'(ptr_reg - CW'(1));
                rd_vld_next  = 1'b1;
                ptr_next     = ptr_reg - CW'(1);
            end else begin
                rd_vld_next = 1'b0;
                if (!rd_vld_reg) begin
                    we         = 1'b1;
                    waddr      = AW'(idx_reg);
                    wdata      = val_reg;
                    count_next = count_reg + CW'(1);
                end
            end
        end

        // shift down: first read is the removed element, the rest move one lower
        if (cmd.shift_dn) begin
            if (rd_vld_reg) begin
                if (rd_addr_reg == AW'(idx_reg)) begin
                    res_data_next = rdata_reg;
                end else begin
                    we    = 1'b1;
                    waddr = rd_addr_reg - AW'(1);
                end
            end
            if (ptr_reg < count_reg) begin
                re           = 1'b1;
                raddr        = AW'(ptr_reg);
                rd_addr_next = AW'(ptr_reg);
                rd_vld_next  = 1'b1;
                ptr_next     = ptr_reg + CW'(1);
            end else begin
                rd_vld_next = 1'b0;
                if (!rd_vld_reg) begin
                    count_next = count_reg - CW'(1);
                end
            end
        end

        if (cmd.rd_issue) begin
            re    = 1'b1;
            raddr = AW'(ptr_reg);
        end

        if (cmd.load_elem) begin
            ptr_next = ptr_reg + CW'(1);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_elem || cmd.load_single) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg  <= op_t'(s_opcode);
            val_reg <= s_value;
            pos_reg <= s_position;
        end
        ptr_reg      <= ptr_next;
        idx_reg      <= idx_next;
        rd_addr_reg  <= rd_addr_next;
        res_code_reg <= res_code_next;
        res_data_reg <= res_data_next;
        if (cmd.load_elem) begin
            m_status_reg <= ST_OK;
            m_data_reg   <= rdata_reg;
            m_count_reg  <= CNT_OUT_W'(count_reg);
            m_last_reg   <= st.rd_last;
        end else if (cmd.load_single) begin
            m_status_reg <= res_code_reg;
            m_data_reg   <= res_data_reg;
            m_count_reg  <= CNT_OUT_W'(count_reg);
            m_last_reg   <= 1'b1;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_data_out = m_data_reg;
    assign m_count    = m_count_reg;
    assign m_last     = m_last_reg;

endmodule

`default_nettype wire

// File: sv/positional_circular_list_engine.sv
// list engine top: one transaction at a time; shifts move one element per cycle through the
// store's single read port and single write port; a read-out issues a store read for each
// element, then loads it into the result register once the output is free
// the next transaction is taken in the cycle after the last result is loaded, later under stalls
// reset clears the element count and result valid; the store is left as is, no clearing pass
`default_nettype none

module positional_circular_list_engine
    import pcle_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [OP_W-1:0]          s_opcode,
    input  wire logic signed [DATA_W-1:0] s_value,
    input  wire logic [POS_W-1:0]         s_position,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [ST_W-1:0]               m_status,
    output logic signed [DATA_W-1:0]      m_data_out,
    output logic [CNT_OUT_W-1:0]          m_count,
    output logic                          m_last
);

    cmd_t  cmd;
    stat_t st;

    pcle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    pcle_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_opcode   (s_opcode),
        .s_value    (s_value),
        .s_position (s_position),
        .cmd        (cmd),
        .st         (st),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_data_out (m_data_out),
        .m_count    (m_count),
        .m_last     (m_last)
    );

endmodule

`default_nettype wire
